/* design/lsb_rgb_payload_extractor_defines.svh */
// Assertion macros shared by the payload extractor modules.
`ifndef LSB_RGB_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define LSB_RGB_PAYLOAD_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH
`define LSBRGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lsbrgb assertion failed");
`define LSBRGB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lsbrgb assertion failed");
`else
`define LSBRGB_ASSERT(lbl, prop)
`define LSBRGB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* design/lsbrgb_pkg.sv */
// Types, constants and the marker table of the RGB payload extractor.
`default_nettype none

package lsbrgb_pkg;

  localparam int PIXEL_COUNT_BITS = 26;
  localparam int CNT_W            = PIXEL_COUNT_BITS;
  localparam int PIX_W            = 27;
  localparam int CAP_W            = PIX_W + 2 - 3;
  localparam int LEN_W            = 32;
  localparam int FIFO_DEPTH       = 4;
  localparam int PTR_W            = $clog2(FIFO_DEPTH);
  localparam int FCNT_W           = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] ST_DATA       = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN   = 2'd1;
  localparam logic [1:0] ST_OVER_CAP   = 2'd2;
  localparam logic [1:0] ST_BAD_MARKER = 2'd3;

  localparam logic CFG_PIXEL_COUNT = 1'b0;
  localparam logic CFG_MARKER_MODE = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       first_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] status;
  } out_item_t;

  // One queue entry: an image restart, a completed byte, or both.
  typedef struct packed {
    logic       restart;
    logic       byte_vld;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic             marker_mode;
  } cfg_t;

  function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0:    v = 8'h50;
      2'd1:    v = 8'h52;
      2'd2:    v = 8'h54;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/lsbrgb_front.sv */
// Front end: gathers the color LSBs of each pixel into MSB-first bytes.
`default_nettype none

module lsbrgb_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lsbrgb_pkg::in_item_t in_item,
  input  wire logic                q_full,
  output logic                     q_push,
  output lsbrgb_pkg::q_entry_t     q_entry
);

  logic [7:0] buf_r, buf_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       done_byte;
  logic [7:0] byte_val;
  logic [2:0] bits;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign bits     = {in_item.red[0], in_item.green[0], in_item.blue[0]};

  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    done_byte = 1'b0;
    byte_val  = 8'h00;
    if (in_item.first_pixel) begin
      buf_nxt = 8'h00;
      cnt_nxt = 3'd0;
    end
    // Red first, then green, then blue.
    for (int i = 2; i >= 0; i--) begin
      buf_nxt = {buf_nxt[6:0], bits[i]};
      cnt_nxt = cnt_nxt + 3'd1;
      if (cnt_nxt == 3'd0) begin
        done_byte = 1'b1;
        byte_val  = buf_nxt;
        buf_nxt   = 8'h00;
      end
    end
  end

  assign q_push           = accept && (in_item.first_pixel || done_byte);
  assign q_entry.restart  = in_item.first_pixel;
  assign q_entry.byte_vld = done_byte;
  assign q_entry.data     = byte_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= 8'h00;
      cnt_r <= 3'd0;
    end else if (accept) begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lsbrgb_fifo.sv */
// Short queue of byte and restart entries between front and back end.
`default_nettype none

`include "lsb_rgb_payload_extractor_defines.svh"

module lsbrgb_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lsbrgb_pkg::q_entry_t wr_entry,
  input  wire logic                 pop,
  output lsbrgb_pkg::q_entry_t      rd_entry,
  output logic                      not_empty,
  output logic                      full
);

  lsbrgb_pkg::q_entry_t mem_r [lsbrgb_pkg::FIFO_DEPTH];
  logic [lsbrgb_pkg::PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [lsbrgb_pkg::FCNT_W-1:0] count_r;

  localparam logic [lsbrgb_pkg::FCNT_W-1:0] DEPTH_C =
    lsbrgb_pkg::FCNT_W'(lsbrgb_pkg::FIFO_DEPTH);
  localparam logic [lsbrgb_pkg::PTR_W-1:0] LAST_PTR =
    lsbrgb_pkg::PTR_W'(lsbrgb_pkg::FIFO_DEPTH - 1);

  assign not_empty = (count_r != '0);
  assign full      = (count_r == DEPTH_C);
  assign rd_entry  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `LSBRGB_ASSERT(a_no_push_full, full |-> !push)
  `LSBRGB_ASSERT(a_no_pop_empty, !not_empty |-> !pop)
  `LSBRGB_ASSERT(a_count_up, (push && !pop) |=> count_r == $past(count_r) + 1'b1)

endmodule

`default_nettype wire

/* design/lsbrgb_back.sv */
// Back end: decodes the length header, checks capacity and marker, emits bytes.
`default_nettype none

`include "lsb_rgb_payload_extractor_defines.svh"

module lsbrgb_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lsbrgb_pkg::cfg_t     cfg,
  input  wire logic                 q_not_empty,
  input  wire lsbrgb_pkg::q_entry_t q_entry,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lsbrgb_pkg::out_item_t     out_item
);

  localparam int CNT_W = lsbrgb_pkg::CNT_W;
  localparam int LEN_W = lsbrgb_pkg::LEN_W;
  localparam int CAP_W = lsbrgb_pkg::CAP_W;

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_PAY  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             out_valid_r;
  lsbrgb_pkg::out_item_t out_r, res;
  logic             res_vld;
  logic [CNT_W-1:0] idx;
  logic             fin;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    res_vld       = 1'b0;
    res.data_byte = 8'h00;
    res.last_byte = 1'b1;
    res.status    = lsbrgb_pkg::ST_DATA;
    idx           = cnt_r;
    fin           = 1'b0;
    if (q_pop) begin
      if (q_entry.restart) begin
        phase_nxt = PH_HDR;
        cnt_nxt   = '0;
        len_nxt   = '0;
      end
      if (q_entry.byte_vld) begin
        unique case (phase_nxt)
          PH_HDR: begin
            len_nxt = {len_nxt[LEN_W-9:0], q_entry.data};
            if (cnt_nxt[1:0] == 2'd3) begin
              cnt_nxt = '0;
              // Over capacity when length + 8 exceeds floor(3 * pixels / 8).
              if (len_nxt == '0) begin
                phase_nxt  = PH_DONE;
                res_vld    = 1'b1;
                res.status = lsbrgb_pkg::ST_ZERO_LEN;
              end else if (({1'b0, len_nxt} + (LEN_W+1)'(8)) >
                           {{(LEN_W+1-CAP_W){1'b0}}, cfg.cap}) begin
                phase_nxt  = PH_DONE;
                res_vld    = 1'b1;
                res.status = lsbrgb_pkg::ST_OVER_CAP;
              end else begin
                phase_nxt = PH_PAY;
              end
            end else begin
              cnt_nxt = cnt_nxt + 1'b1;
            end
          end
          PH_PAY: begin
            idx     = cnt_nxt;
            cnt_nxt = idx + 1'b1;
            fin     = (cnt_nxt == len_nxt[CNT_W-1:0]);
            if (cfg.marker_mode && (idx[CNT_W-1:2] == '0)) begin
              if ((q_entry.data != lsbrgb_pkg::prefix_byte(idx[1:0])) || fin) begin
                phase_nxt  = PH_DONE;
                res_vld    = 1'b1;
                res.status = lsbrgb_pkg::ST_BAD_MARKER;
              end
            end else begin
              res_vld       = 1'b1;
              res.data_byte = q_entry.data;
              res.last_byte = fin;
              if (fin) begin
                phase_nxt = PH_DONE;
              end
            end
          end
          default: begin
            // Done, and the unused code: bytes are dropped until a restart.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      cnt_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      if (q_pop) begin
        out_valid_r <= res_vld;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_vld) begin
      out_r <= res;
    end
  end

  `LSBRGB_ASSERT(a_err_is_last,
    (out_valid_r && out_r.status != lsbrgb_pkg::ST_DATA) |-> out_r.last_byte)
  `LSBRGB_ASSERT(a_quiet_after_last,
    (out_valid_r && out_r.last_byte && !out_stall) |=> !out_valid_r)

endmodule

`default_nettype wire

/* design/lsb_rgb_payload_extractor.sv */
// Top level of the RGB least-significant-bit payload extractor.
//
//   channel | direction | ports                                 | handshake
//   --------+-----------+---------------------------------------+----------------
//   in      | input     | in_valid, in_stall, in_item           | valid && !stall
//   out     | output    | out_valid, out_stall, out_item        | valid && !stall
//   cfg     | input     | cfg_we, cfg_index, cfg_wdata          | cfg_we
//
// One pixel is accepted per clock while the four-entry byte queue has room.
// A result passes from the pixel that completes its byte through the byte queue
// into the output register; the back end retires one queue entry per clock while the output register is empty or taken.
// Output stall holds the output register and backs up the queue, then in_stall.
// Reset is synchronous and clears all control state and both configuration registers.
`default_nettype none

module lsb_rgb_payload_extractor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lsbrgb_pkg::in_item_t            in_item,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output lsbrgb_pkg::out_item_t                out_item,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [lsbrgb_pkg::PIX_W-1:0]    cfg_wdata
);

  localparam int PIX_W = lsbrgb_pkg::PIX_W;

  logic [lsbrgb_pkg::CAP_W-1:0] cap_r;
  logic                         marker_r;
  logic [PIX_W+1:0]             triple;
  lsbrgb_pkg::cfg_t             cfg;

  logic                 q_push, q_pop, q_full, q_not_empty;
  lsbrgb_pkg::q_entry_t q_wr, q_rd;

  // Capacity is kept as floor(3 * pixel_count / 8).
  assign triple = {2'b00, cfg_wdata} + {1'b0, cfg_wdata, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= '0;
      marker_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsbrgb_pkg::CFG_PIXEL_COUNT: cap_r    <= triple[PIX_W+1:3];
        lsbrgb_pkg::CFG_MARKER_MODE: marker_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.cap         = cap_r;
  assign cfg.marker_mode = marker_r;

  lsbrgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wr)
  );

  lsbrgb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_entry  (q_wr),
    .pop       (q_pop),
    .rd_entry  (q_rd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lsbrgb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_entry     (q_rd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

/* sim/lsb_rgb_payload_extractor_checker.sv */
// Checker for the RGB payload extractor: predicts every result and compares it.
`timescale 1ns / 1ps

module lsb_rgb_payload_extractor_checker
  import lsbrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [PIX_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               results_pending
);

  typedef enum logic [1:0] {READ_LENGTH, READ_PAYLOAD, FINISHED} stage_e;

  // Version tag expected at the head of the payload, first byte in the top bits.
  localparam logic [31:0] VERSION_TAG = 32'h5052_5401;

  logic [PIX_W-1:0] image_pixels;
  logic             strip_tag;
  logic [7:0]       shift_byte;
  logic [2:0]       shift_bits;
  logic [CNT_W-1:0] byte_idx;
  logic [LEN_W-1:0] length_field;
  stage_e           stage;
  out_item_t        awaited_bytes[$];
  int               mismatch_total;

  task automatic report_mismatch(input string what);
    $display("%0t ns extractor checker: %s", $time, what);
    mismatch_total++;
  endtask

  task automatic restart_image();
    shift_byte   = '0;
    shift_bits   = '0;
    byte_idx     = '0;
    length_field = '0;
    stage        = READ_LENGTH;
  endtask

  task automatic take_byte(input logic [7:0] b);
    longint           room;
    logic [CNT_W-1:0] idx;
    logic             fin;
    if (stage == READ_LENGTH) begin
      length_field = {length_field[LEN_W-9:0], b};
      byte_idx = byte_idx + 1'b1;
      if (byte_idx == CNT_W'(4)) begin
        byte_idx = '0;
        // Signed on purpose: small images give a negative capacity.
        room = (longint'(image_pixels) * 3 - 32) / 8 - 4;
        if (length_field == '0) begin
          stage = FINISHED;
          awaited_bytes.push_back({8'h00, 1'b1, ST_ZERO_LEN});
        end else if (room < 0 || longint'(length_field) > room) begin
          stage = FINISHED;
          awaited_bytes.push_back({8'h00, 1'b1, ST_OVER_CAP});
        end else begin
          stage = READ_PAYLOAD;
        end
      end
    end else begin
      idx = byte_idx;
      byte_idx = idx + 1'b1;
      fin = (byte_idx == length_field[CNT_W-1:0]);
      if (strip_tag && idx < 4) begin
        if (b != VERSION_TAG[31 - 8 * idx[1:0] -: 8] || fin) begin
          stage = FINISHED;
          awaited_bytes.push_back({8'h00, 1'b1, ST_BAD_MARKER});
        end
      end else begin
        if (fin) stage = FINISHED;
        awaited_bytes.push_back({b, fin, ST_DATA});
      end
    end
  endtask

  task automatic absorb_pixel(input in_item_t px);
    logic [2:0] lsbs;
    lsbs = {px.red[0], px.green[0], px.blue[0]};
    if (px.first_pixel) restart_image();
    for (int k = 2; k >= 0; k--) begin
      if (stage != FINISHED) begin
        shift_byte = {shift_byte[6:0], lsbs[k]};
        shift_bits = shift_bits + 1'b1;
        if (shift_bits == 3'd0) begin
          take_byte(shift_byte);
          shift_byte = '0;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      image_pixels = '0;
      strip_tag    = 1'b0;
      restart_image();
      awaited_bytes.delete();
      mismatch_total = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PIXEL_COUNT) begin
          image_pixels = cfg_wdata;
        end else begin
          strip_tag = cfg_wdata[0];
        end
      end
      if (in_valid && !in_stall) absorb_pixel(in_item);
      if (out_valid && !out_stall) begin
        if (awaited_bytes.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing expected", out_item));
        end else begin
          want = awaited_bytes.pop_front();
          if (out_item.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, expected %h",
                                      out_item.data_byte, want.data_byte));
          if (out_item.last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %b, expected %b",
                                      out_item.last_byte, want.last_byte));
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item.status, want.status));
        end
      end
    end
    fail_count      <= mismatch_total;
    results_pending <= awaited_bytes.size();
  end

endmodule

/* sim/tb_lsb_rgb_payload_extractor.sv */
// Testbench top for the RGB payload extractor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_lsb_rgb_payload_extractor;
  import lsbrgb_pkg::*;

  localparam int NUM_SETUPS     = 8;
  localparam int SETUP_PIXELS   = 210;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [PIX_W-1:0] MAX_PIXELS = PIX_W'(67108864);

  typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_we;
  logic             cfg_index;
  logic [PIX_W-1:0] cfg_wdata;
  int               fail_count;
  int               results_pending;

  pace_e            pace = PACE_FREE;
  logic [PIX_W-1:0] cur_pixels;
  bit               cur_tagged;
  int               pixels_sent;
  int               hold_requests;
  int               holds_served;
  int               hold_left;
  int               quiet_cycles;

  lsb_rgb_payload_extractor dut (.*);

  lsb_rgb_payload_extractor_checker scoreboard (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one pixel, possibly after idle cycles, and returns once it is taken.
  task automatic push_pixel(input in_item_t px);
    int rest_pct;
    rest_pct = (pace == PACE_SENDER) ? 70 : (pace == PACE_BOTH) ? 17 : 0;
    while ($urandom_range(0, 99) < rest_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Builds one image: a length header and payload bytes carried in the
  // pixel LSBs, sometimes cut short or followed by pixels that are ignored.
  task automatic send_image();
    longint           room;
    logic [LEN_W-1:0] len;
    int               pick;
    int               nbytes;
    int               spare;
    logic [7:0]       body[$];
    bit               stream[$];
    in_item_t         px;
    room = (longint'(cur_pixels) * 3 - 32) / 8 - 4;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      len = '0;
    end else if (pick < 10) begin
      len = $urandom();
    end else if (pick < 16 && room >= 0) begin
      len = LEN_W'(room + 1);
    end else if (pick < 24 && cur_tagged) begin
      len = $urandom_range(1, 4);
    end else if (room < 1) begin
      len = $urandom_range(1, 6);
    end else begin
      len = $urandom_range(1, int'(room < 24 ? room : 24));
    end

    nbytes = (len != 0 && room >= 0 && longint'(len) <= room) ? int'(len) : 0;
    if (nbytes > 64) begin
      nbytes = $urandom_range(0, 64);
    end else if (nbytes > 0 && $urandom_range(0, 19) == 0) begin
      nbytes = $urandom_range(0, nbytes - 1);
    end
    for (int i = 0; i < nbytes; i++) body.push_back(8'($urandom()));
    if (cur_tagged && $urandom_range(0, 99) < 85) begin
      for (int i = 0; i < 4 && i < nbytes; i++) body[i] = prefix_byte(2'(i));
      if (nbytes > 0 && $urandom_range(0, 4) == 0) begin
        spare = $urandom_range(0, nbytes - 1 < 3 ? nbytes - 1 : 3);
        body[spare] ^= 8'(1) << $urandom_range(0, 7);
      end
    end

    for (int i = LEN_W - 1; i >= 0; i--) stream.push_back(len[i]);
    foreach (body[j]) begin
      for (int i = 7; i >= 0; i--) stream.push_back(body[j][i]);
    end

    for (int p = 0; p < stream.size(); p += 3) begin
      px = 25'($urandom());
      px.first_pixel = (p == 0);
      px.red[0] = stream[p];
      if (p + 1 < stream.size()) px.green[0] = stream[p + 1];
      if (p + 2 < stream.size()) px.blue[0] = stream[p + 2];
      push_pixel(px);
    end
    spare = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (spare) begin
      px = 25'($urandom());
      px.first_pixel = 1'b0;
      push_pixel(px);
    end
  endtask

  // Receiver: random stalls by pace, plus long hold-offs on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) <
                      ((pace == PACE_RECEIVER) ? 70 : (pace == PACE_BOTH) ? 17 : 0));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int goal;
    int images;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PIXEL_COUNT;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Pixels before any first pixel run from reset: a zero length, then an
    // ignored pixel, then a restart whose all-ones length exceeds capacity.
    repeat (11) push_pixel({8'hFE, 8'hFE, 8'hFE, 1'b0});
    push_pixel({8'hFF, 8'hFF, 8'hFF, 1'b0});
    push_pixel({8'h01, 8'h01, 8'h01, 1'b1});
    repeat (10) push_pixel({8'h01, 8'h01, 8'h01, 1'b0});
    drain_results(SETTLE_CYCLES);

    for (int s = 0; s < NUM_SETUPS; s++) begin
      case (s)
        0:       begin cur_pixels = PIX_W'(40);  cur_tagged = 1'b0; end
        1:       begin cur_pixels = PIX_W'(54);  cur_tagged = 1'b1; end
        2:       begin cur_pixels = '0;          cur_tagged = 1'b1; end
        3:       begin cur_pixels = MAX_PIXELS;  cur_tagged = 1'b0; end
        4:       begin cur_pixels = MAX_PIXELS;  cur_tagged = 1'b1; end
        5:       begin cur_pixels = PIX_W'(11);  cur_tagged = 1'b0; end
        6:       begin cur_pixels = PIX_W'(200); cur_tagged = 1'b1; end
        default: begin cur_pixels = PIX_W'(97);  cur_tagged = 1'b0; end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CFG_PIXEL_COUNT;
      cfg_wdata <= cur_pixels;
      @(posedge clk);
      cfg_index <= CFG_MARKER_MODE;
      cfg_wdata <= PIX_W'(cur_tagged);
      @(posedge clk);
      cfg_we <= 1'b0;

      pace = pace_e'(s % 4);
      // With no sender gaps, a long receiver hold-off backs up the queue.
      if (pace == PACE_FREE) hold_requests++;
      goal = pixels_sent + SETUP_PIXELS;
      images = 0;
      while (pixels_sent < goal) begin
        send_image();
        images++;
        if ((s == 2 && images == 2) || $urandom_range(0, 24) == 0) drain_results(0);
      end
      drain_results(SETTLE_CYCLES);
    end

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/lsbrgb_pkg.sv
design/lsbrgb_front.sv
design/lsbrgb_fifo.sv
design/lsbrgb_back.sv
design/lsb_rgb_payload_extractor.sv
sim/lsb_rgb_payload_extractor_checker.sv
sim/tb_lsb_rgb_payload_extractor.sv
